FILE: hdl/cca_pkg.sv
package cca_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int VOL_W       = 32;
    localparam int LEN_CFG_W   = 7;
    localparam int SUM_W       = 64;
    localparam int CORR_W      = 48;
    localparam int LAG_W       = 6;
    localparam int S_TDATA_W   = 2 * SAMPLE_W;
    localparam int M_TDATA_W   = 104;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SERIES_LENGTH     = 1'b0,
        CFG_VOLUME_RECIPROCAL = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_ISSUE,
        MAC_DRAIN
    } mac_state_t;

    typedef enum logic [1:0] {
        AVG_IDLE,
        AVG_RUN,
        AVG_DONE
    } avg_state_t;

    // control that travels with each read pair through the product pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             lag_last;
        logic [LAG_W-1:0] lag;
    } mac_ctl_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_real;
        logic signed [SUM_W-1:0] sum_imag;
        logic [LAG_W-1:0]        lag;
        logic                    last;
    } avg_req_t;

    typedef struct packed {
        logic [CORR_W-1:0] corr_real;
        logic [CORR_W-1:0] corr_imag;
        logic [LAG_W-1:0]  lag;
        logic              last;
    } avg_res_t;

endpackage

FILE: hdl/cca_avg.sv
module cca_avg #(
    parameter int LEN_W = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [LEN_W-1:0]   len,
    input  cca_pkg::avg_req_t  req,
    input  logic               req_valid,
    output logic               req_ready,
    output cca_pkg::avg_res_t  res,
    output logic               res_valid,
    input  logic               res_ready
);

    localparam int SW    = cca_pkg::SUM_W;
    localparam int CW    = cca_pkg::CORR_W;
    localparam int CNT_W = $clog2(SW);
    localparam logic [SW-1:0] POS_MAX = (SW'(1) << (CW - 1)) - SW'(1);
    localparam logic [SW-1:0] NEG_MAX = SW'(1) << (CW - 1);

    cca_pkg::avg_state_t state_reg, state_next;

    logic [CNT_W-1:0]          cnt_reg;
    logic [SW-1:0]             num_re_reg, num_im_reg;
    logic [LEN_W-1:0]          rem_re_reg, rem_im_reg;
    logic [LEN_W-1:0]          div_reg;
    logic                      neg_re_reg, neg_im_reg;
    logic [cca_pkg::LAG_W-1:0] lag_reg;
    logic                      last_reg;

    logic          take;
    logic [SW-1:0] mag_re, mag_im, half;
    logic [LEN_W:0] step_re, step_im;

    // one restoring step: returns {new remainder, quotient bit}
    function automatic logic [LEN_W:0] div_step(input logic [LEN_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [LEN_W-1:0] d);
        logic [LEN_W:0] wide;
        logic [LEN_W:0] diff;
        wide = {rem, bit_in};
        diff = wide - {1'b0, d};
        if (wide >= {1'b0, d}) begin
            return {diff[LEN_W-1:0], 1'b1};
        end else begin
            return {wide[LEN_W-1:0], 1'b0};
        end
    endfunction

    function automatic logic [CW-1:0] sat_sign(input logic neg, input logic [SW-1:0] q);
        logic [SW-1:0] c;
        if (neg) begin
            c = (q > NEG_MAX) ? NEG_MAX : q;
            return CW'(SW'(0) - c);
        end else begin
            c = (q > POS_MAX) ? POS_MAX : q;
            return CW'(c);
        end
    endfunction

    assign take = req_valid && req_ready;
    assign half = SW'(len >> 1);
    assign mag_re = req.sum_real[SW-1] ? (SW'(0) - SW'(req.sum_real)) : SW'(req.sum_real);
    assign mag_im = req.sum_imag[SW-1] ? (SW'(0) - SW'(req.sum_imag)) : SW'(req.sum_imag);

    assign step_re = div_step(rem_re_reg, num_re_reg[SW-1], div_reg);
    assign step_im = div_step(rem_im_reg, num_im_reg[SW-1], div_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cca_pkg::AVG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            cca_pkg::AVG_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    state_next = cca_pkg::AVG_RUN;
                end
            end
            cca_pkg::AVG_RUN: begin
                if (cnt_reg == CNT_W'(SW - 1)) begin
                    state_next = cca_pkg::AVG_DONE;
                end
            end
            cca_pkg::AVG_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = cca_pkg::AVG_IDLE;
                end
            end
            default: begin
                state_next = cca_pkg::AVG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            num_re_reg <= mag_re + half;
            num_im_reg <= mag_im + half;
            rem_re_reg <= '0;
            rem_im_reg <= '0;
            div_reg    <= len;
            neg_re_reg <= req.sum_real[SW-1];
            neg_im_reg <= req.sum_imag[SW-1];
            lag_reg    <= req.lag;
            last_reg   <= req.last;
            cnt_reg    <= '0;
        end else if (state_reg == cca_pkg::AVG_RUN) begin
            // shift the quotient bit in where the dividend bit leaves
            num_re_reg <= {num_re_reg[SW-2:0], step_re[0]};
            num_im_reg <= {num_im_reg[SW-2:0], step_im[0]};
            rem_re_reg <= step_re[LEN_W:1];
            rem_im_reg <= step_im[LEN_W:1];
            cnt_reg    <= cnt_reg + CNT_W'(1);
        end
    end

    assign res.corr_real = sat_sign(neg_re_reg, num_re_reg);
    assign res.corr_imag = sat_sign(neg_im_reg, num_im_reg);
    assign res.lag       = lag_reg;
    assign res.last      = last_reg;

endmodule

FILE: hdl/circular_complex_autocorrelation.sv
// Loading: one sample per cycle while input is not stalled, no result until the last
// sample of a series.
// Each lag then runs the shared complex multiply-accumulate over the two read ports
// of the sample memory, then the bit-serial averager, which overlaps the next lag.
// Input stalls from the last sample until the final lag sum goes to the averager.
// aresetn (synchronous, active low) clears control and the registers to 64 and 1.0.
module circular_complex_autocorrelation #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cca_pkg::S_TDATA_W-1:0]     s_tdata,   // sample_real, sample_imag
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cca_pkg::M_TDATA_W-1:0]     m_tdata,   // lag, corr_real, corr_imag
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cca_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cca_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW  = $clog2(MAX_LENGTH + 1);
    localparam int SMW = cca_pkg::SAMPLE_W;
    localparam int SW  = cca_pkg::SUM_W;

    // configuration
    logic [cca_pkg::LEN_CFG_W-1:0] series_length_reg;
    logic [cca_pkg::VOL_W-1:0]     volume_reciprocal_reg;
    logic [LW-1:0]                 eff_len;

    // load path
    logic                    s_accept, load_done, busy_reg;
    logic [AW-1:0]           load_count_reg;
    logic                    a_valid_reg, b_valid_reg;
    logic signed [SMW-1:0]   a_re_reg, a_im_reg;
    logic [AW-1:0]           a_addr_reg, b_addr_reg;
    logic                    a_done_reg, b_done_reg;
    logic signed [2*SMW:0]   b_prod_re_reg, b_prod_im_reg;
    logic signed [2*SMW:0]   prod_re_next, prod_im_next;
    logic signed [SMW-1:0]   scaled_re, scaled_im;
    logic [LW-1:0]           len_reg;

    // sample memory
    logic [2*SMW-1:0] mem [MAX_LENGTH];
    logic [2*SMW-1:0] rd_a_reg, rd_b_reg;

    // correlation sequencer and pipeline
    cca_pkg::mac_state_t mac_state_reg, mac_state_next;
    logic [AW-1:0]       t_reg, t0_reg, t1_reg;
    logic                mac_start, issue_valid, issue_last, lag_last;
    cca_pkg::mac_ctl_t   issue_ctl, r1_ctl_reg, r2_ctl_reg, r3_ctl_reg;
    logic signed [SW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [SW-1:0] re_term_reg, im_term_reg;
    logic signed [SW-1:0] acc_re_reg, acc_im_reg;
    logic                 sum_valid_reg, sum_last_reg;
    logic [cca_pkg::LAG_W-1:0] sum_lag_reg;

    // averager and output
    cca_pkg::avg_req_t avg_req;
    cca_pkg::avg_res_t avg_res;
    logic              avg_req_ready, avg_res_valid, avg_res_ready, avg_take;
    logic              m_tvalid_reg, m_tlast_reg;
    logic [cca_pkg::M_TDATA_W-1:0] m_tdata_reg;

    function automatic logic signed [SMW-1:0] scale_round(input logic signed [2*SMW:0] p);
        logic signed [2*SMW:0] r;
        logic signed [SMW+1:0] s;
        r = p + (65'sd1 <<< 30);
        s = $signed(r[2*SMW:SMW-1]);
        if (s > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (s < -34'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return s[SMW-1:0];
        end
    endfunction

    function automatic logic signed [SW-1:0] round_q16(input logic signed [SW-1:0] p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            series_length_reg     <= 7'd64;
            volume_reciprocal_reg <= 32'h8000_0000;
        end else if (cfg_valid) begin
            unique case (cca_pkg::cfg_index_t'(cfg_index))
                cca_pkg::CFG_SERIES_LENGTH: begin
                    series_length_reg <= cfg_data[cca_pkg::LEN_CFG_W-1:0];
                end
                cca_pkg::CFG_VOLUME_RECIPROCAL: begin
                    volume_reciprocal_reg <= cfg_data[cca_pkg::VOL_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        if (series_length_reg == '0) begin
            eff_len = LW'(1);
        end else if (32'(series_length_reg) > MAX_LENGTH) begin
            eff_len = LW'(MAX_LENGTH);
        end else begin
            eff_len = LW'(series_length_reg);
        end
    end

    // ---------------- load and scale ----------------
    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign load_done = (LW'(load_count_reg) + LW'(1)) >= eff_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            busy_reg       <= 1'b0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
        end else begin
            a_valid_reg <= s_accept;
            b_valid_reg <= a_valid_reg;
            if (s_accept) begin
                load_count_reg <= load_done ? '0 : load_count_reg + AW'(1);
            end
            // hold input off while the series is being read back
            if (s_accept && load_done) begin
                busy_reg <= 1'b1;
            end else if (avg_take && sum_last_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign prod_re_next = 65'(a_re_reg) * 65'($signed({1'b0, volume_reciprocal_reg}));
    assign prod_im_next = 65'(a_im_reg) * 65'($signed({1'b0, volume_reciprocal_reg}));

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_re_reg   <= $signed(s_tdata[SMW-1:0]);
            a_im_reg   <= $signed(s_tdata[2*SMW-1:SMW]);
            a_addr_reg <= load_count_reg;
            a_done_reg <= load_done;
        end
        if (s_accept && load_done) begin
            len_reg <= eff_len;
        end
        b_prod_re_reg <= prod_re_next;
        b_prod_im_reg <= prod_im_next;
        b_addr_reg    <= a_addr_reg;
        b_done_reg    <= a_done_reg;
    end

    assign scaled_re = scale_round(b_prod_re_reg);
    assign scaled_im = scale_round(b_prod_im_reg);
    assign mac_start = b_valid_reg && b_done_reg;

    // ---------------- sample memory ----------------
    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            mem[b_addr_reg] <= {scaled_im, scaled_re};
        end
        rd_a_reg <= mem[t0_reg];
        rd_b_reg <= mem[t1_reg];
    end

    // ---------------- correlation sequencer ----------------
    assign issue_valid = (mac_state_reg == cca_pkg::MAC_ISSUE);
    assign issue_last  = LW'(t0_reg) == (len_reg - LW'(1));
    assign lag_last    = LW'(t_reg) == (len_reg - LW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_state_reg <= cca_pkg::MAC_IDLE;
        end else begin
            mac_state_reg <= mac_state_next;
        end
    end

    always_comb begin
        mac_state_next = mac_state_reg;
        unique case (mac_state_reg)
            cca_pkg::MAC_IDLE: begin
                if (mac_start) begin
                    mac_state_next = cca_pkg::MAC_ISSUE;
                end
            end
            cca_pkg::MAC_ISSUE: begin
                if (issue_last) begin
                    mac_state_next = cca_pkg::MAC_DRAIN;
                end
            end
            cca_pkg::MAC_DRAIN: begin
                // the accumulator doubles as the hand-off register: wait until taken
                if (avg_take) begin
                    mac_state_next = lag_last ? cca_pkg::MAC_IDLE : cca_pkg::MAC_ISSUE;
                end
            end
            default: begin
                mac_state_next = cca_pkg::MAC_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg  <= '0;
            t0_reg <= '0;
            t1_reg <= '0;
        end else begin
            if (mac_state_reg == cca_pkg::MAC_IDLE) begin
                t_reg  <= '0;
                t0_reg <= '0;
                t1_reg <= '0;
            end else if (issue_valid) begin
                t0_reg <= issue_last ? '0 : t0_reg + AW'(1);
                t1_reg <= ((LW'(t1_reg) + LW'(1)) == len_reg) ? '0 : t1_reg + AW'(1);
            end else if (avg_take && !lag_last) begin
                t_reg  <= t_reg + AW'(1);
                t1_reg <= t_reg + AW'(1);
            end
        end
    end

    assign issue_ctl.valid    = issue_valid;
    assign issue_ctl.first    = (t0_reg == '0);
    assign issue_ctl.last     = issue_last;
    assign issue_ctl.lag_last = lag_last;
    assign issue_ctl.lag      = cca_pkg::LAG_W'(t_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_ctl_reg    <= '0;
            r2_ctl_reg    <= '0;
            r3_ctl_reg    <= '0;
            sum_valid_reg <= 1'b0;
        end else begin
            r1_ctl_reg <= issue_ctl;
            r2_ctl_reg <= r1_ctl_reg;
            r3_ctl_reg <= r2_ctl_reg;
            if (r3_ctl_reg.valid && r3_ctl_reg.last) begin
                sum_valid_reg <= 1'b1;
            end else if (avg_take) begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_rr_reg <= $signed(rd_a_reg[SMW-1:0])     * $signed(rd_b_reg[SMW-1:0]);
        p_ii_reg <= $signed(rd_a_reg[2*SMW-1:SMW]) * $signed(rd_b_reg[2*SMW-1:SMW]);
        p_ri_reg <= $signed(rd_a_reg[SMW-1:0])     * $signed(rd_b_reg[2*SMW-1:SMW]);
        p_ir_reg <= $signed(rd_a_reg[2*SMW-1:SMW]) * $signed(rd_b_reg[SMW-1:0]);
        re_term_reg <= round_q16(p_rr_reg) - round_q16(p_ii_reg);
        im_term_reg <= round_q16(p_ri_reg) + round_q16(p_ir_reg);
        if (r3_ctl_reg.valid) begin
            acc_re_reg <= r3_ctl_reg.first ? re_term_reg : acc_re_reg + re_term_reg;
            acc_im_reg <= r3_ctl_reg.first ? im_term_reg : acc_im_reg + im_term_reg;
            if (r3_ctl_reg.last) begin
                sum_lag_reg  <= r3_ctl_reg.lag;
                sum_last_reg <= r3_ctl_reg.lag_last;
            end
        end
    end

    // ---------------- averaging and output ----------------
    assign avg_req.sum_real = acc_re_reg;
    assign avg_req.sum_imag = acc_im_reg;
    assign avg_req.lag      = sum_lag_reg;
    assign avg_req.last     = sum_last_reg;
    assign avg_take         = sum_valid_reg && avg_req_ready;

    cca_avg #(
        .LEN_W (LW)
    ) u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .len       (len_reg),
        .req       (avg_req),
        .req_valid (sum_valid_reg),
        .req_ready (avg_req_ready),
        .res       (avg_res),
        .res_valid (avg_res_valid),
        .res_ready (avg_res_ready)
    );

    assign avg_res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (avg_res_valid && avg_res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (avg_res_valid && avg_res_ready) begin
            m_tdata_reg <= {2'b00, avg_res.corr_imag, avg_res.corr_real, avg_res.lag};
            m_tlast_reg <= avg_res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hdl/cca_checker.sv
module cca_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cca_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset drops any pending result
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reset leaves the block ready to load a new series
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // register writes never stall
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind circular_complex_autocorrelation cca_checker u_cca_checker (.*);
